// ----- design/srb_pkg.sv -----
// Shared types and constants for the serial ring buffers with XON/XOFF flow control.
package srb_pkg;

    localparam int DATA_W     = 8;
    localparam int OPCODE_W   = 3;
    localparam int MARK_W     = 7;
    localparam int FILL_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [OPCODE_W-1:0] OP_LINE_BYTE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_HOST_READ = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HOST_WRITE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TX_READY = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FLUSH_RX = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_CHAR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CHAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_CHAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ENABLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE = 3'd7;

    localparam logic [DATA_W-1:0] RST_STATUS_CHAR = 8'd63;
    localparam logic [DATA_W-1:0] RST_START_CHAR = 8'd126;
    localparam logic [DATA_W-1:0] RST_HOLD_CHAR = 8'd33;
    localparam logic [DATA_W-1:0] RST_ABORT_CHAR = 8'd24;
    localparam logic [MARK_W-1:0] RST_HIGH_MARK = 7'd96;
    localparam logic [MARK_W-1:0] RST_LOW_MARK = 7'd64;

    localparam logic [DATA_W-1:0] CH_XON = 8'h11;
    localparam logic [DATA_W-1:0] CH_XOFF = 8'h13;

    typedef enum logic [1:0] {
        FS_XON_SENT  = 2'd0,
        FS_SEND_XOFF = 2'd1,
        FS_XOFF_SENT = 2'd2,
        FS_SEND_XON  = 2'd3
    } flow_state_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   data_byte;
    } srb_in_t;

    typedef struct packed {
        logic              read_valid;
        logic [DATA_W-1:0] read_data;
        logic              send_valid;
        logic [DATA_W-1:0] send_data;
        logic              write_accepted;
        logic              rx_dropped;
        logic              status_request;
        logic              start_request;
        logic              hold_request;
        logic              abort_request;
        logic [FILL_W-1:0] rx_fill;
        logic              tx_empty;
    } srb_out_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } ring_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } ring_sts_t;

endpackage

// ----- design/srb_ring.sv -----
// Byte ring: storage memory with registered read at the tail, head/tail pointers and fill count.
module srb_ring #(
    parameter int DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  srb_pkg::ring_ctl_t                ctl,
    input  logic [srb_pkg::DATA_W-1:0]        wr_data,
    output logic [srb_pkg::DATA_W-1:0]        rd_data,
    output srb_pkg::ring_sts_t                sts,
    output logic [$clog2(DEPTH)-1:0]          count
);
    import srb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  head_inc, tail_inc;

    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb begin
        head_next  = ctl.push ? head_inc : head_reg;
        tail_next  = ctl.flush ? head_reg : (ctl.pop ? tail_inc : tail_reg);
        count_next = ctl.flush ? '0
                   : count_reg + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // tail entry is read into rd_data_reg every cycle; the caller uses the registered value
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem_reg[head_reg] <= wr_data;
        end
        rd_data_reg <= mem_reg[tail_reg];
    end

    assign rd_data   = rd_data_reg;
    assign count     = count_reg;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CNT_W'(DEPTH - 1));
    assign sts.last  = (count_reg == CNT_W'(1));

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> !sts.full)
        else $error("push into full ring");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> !sts.empty)
        else $error("pop from empty ring");
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.flush |=> (count_reg == '0) && (tail_reg == head_reg))
        else $error("flush did not empty ring");
`endif

endmodule

// ----- design/serial_ring_buffers_xon_xoff.sv -----
// Serial receive/transmit ring buffers with real-time command characters and XON/XOFF control.
// Each input transfer is one event (line byte, host read, host write, transmitter ready,
// receive flush) and yields exactly one result transfer. An item is accepted in ST_IDLE, where
// the tail entries of both ring memories are read; in ST_EXEC the result is formed, pointers
// and flow state are updated and any write goes back to the ring memory, since the memory
// read is registered. The result sits in an output register, so the block moves on while it
// waits to be taken, and stays in ST_EXEC only while that register is still full. Each ring
// keeps at most depth-1 bytes. Configuration registers are to be written by the user through
// cfg_we/cfg_index/cfg_wdata only while idle; the block itself does not enforce this.
module serial_ring_buffers_xon_xoff #(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [srb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  srb_pkg::srb_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output srb_pkg::srb_out_t                 m_data
);
    import srb_pkg::*;

    localparam int RX_CNT_W = $clog2(RX_DEPTH);
    localparam int TX_CNT_W = $clog2(TX_DEPTH);
    localparam int CMP_W    = ((RX_CNT_W > MARK_W) ? RX_CNT_W : MARK_W) + 1;

    // configuration
    logic [DATA_W-1:0] status_char_reg, start_char_reg, hold_char_reg, abort_char_reg;
    logic [MARK_W-1:0] high_mark_reg, low_mark_reg;
    logic              flow_enable_reg, echo_enable_reg;

    ctl_state_t  state_reg, state_next;
    flow_state_t fs_reg, fs_next;
    srb_in_t     item_reg;
    srb_out_t    m_data_reg, res;
    logic        m_valid_reg;
    logic        go;

    ring_ctl_t             rx_ctl, tx_ctl;
    ring_sts_t             rx_sts, tx_sts;
    logic [DATA_W-1:0]     rx_rd_data, tx_rd_data;
    logic [RX_CNT_W-1:0]   rx_count;
    logic [TX_CNT_W-1:0]   tx_count;

    logic [CMP_W-1:0] rx_cnt_ext, rx_inc, rx_dec, rx_fill_after, high_ext, low_ext;
    logic             is_status, is_start, is_hold, is_abort;

    srb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rx_ctl),
        .wr_data (item_reg.data_byte),
        .rd_data (rx_rd_data),
        .sts     (rx_sts),
        .count   (rx_count)
    );

    srb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (tx_ctl),
        .wr_data (item_reg.data_byte),
        .rd_data (tx_rd_data),
        .sts     (tx_sts),
        .count   (tx_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_char_reg <= RST_STATUS_CHAR;
            start_char_reg  <= RST_START_CHAR;
            hold_char_reg   <= RST_HOLD_CHAR;
            abort_char_reg  <= RST_ABORT_CHAR;
            high_mark_reg   <= RST_HIGH_MARK;
            low_mark_reg    <= RST_LOW_MARK;
            flow_enable_reg <= 1'b0;
            echo_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STATUS_CHAR: status_char_reg <= cfg_wdata;
                CFG_START_CHAR:  start_char_reg  <= cfg_wdata;
                CFG_HOLD_CHAR:   hold_char_reg   <= cfg_wdata;
                CFG_ABORT_CHAR:  abort_char_reg  <= cfg_wdata;
                CFG_HIGH_MARK:   high_mark_reg   <= cfg_wdata[MARK_W-1:0];
                CFG_LOW_MARK:    low_mark_reg    <= cfg_wdata[MARK_W-1:0];
                CFG_FLOW_ENABLE: flow_enable_reg <= cfg_wdata[0];
                CFG_ECHO_ENABLE: echo_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // sequencer: accept, then evaluate and write back
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        go         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    go         = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fs_reg      <= FS_XON_SENT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fs_reg    <= fs_next;
            if (go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (go) begin
            m_data_reg <= res;
        end
    end

    // first match wins: status, start, hold, abort
    assign is_status = (item_reg.data_byte == status_char_reg);
    assign is_start  = !is_status && (item_reg.data_byte == start_char_reg);
    assign is_hold   = !is_status && !is_start && (item_reg.data_byte == hold_char_reg);
    assign is_abort  = !is_status && !is_start && !is_hold
                     && (item_reg.data_byte == abort_char_reg);

    assign rx_cnt_ext = CMP_W'(rx_count);
    assign rx_inc     = rx_cnt_ext + 1'b1;
    assign rx_dec     = rx_cnt_ext - 1'b1;
    assign high_ext   = CMP_W'(high_mark_reg);
    assign low_ext    = CMP_W'(low_mark_reg);

    always_comb begin
        res     = '0;
        fs_next = fs_reg;
        rx_ctl  = '0;
        tx_ctl  = '0;
        unique case (item_reg.opcode)
            OP_LINE_BYTE: begin
                tx_ctl.push = echo_enable_reg && !tx_sts.full;
                if (is_status) begin
                    res.status_request = 1'b1;
                end else if (is_start) begin
                    res.start_request = 1'b1;
                end else if (is_hold) begin
                    res.hold_request = 1'b1;
                end else if (is_abort) begin
                    res.abort_request = 1'b1;
                end else if (rx_sts.full) begin
                    res.rx_dropped = 1'b1;
                end else begin
                    rx_ctl.push = 1'b1;
                    if (flow_enable_reg && fs_reg == FS_XON_SENT && rx_inc >= high_ext) begin
                        fs_next = FS_SEND_XOFF;
                    end
                end
            end
            OP_HOST_READ: begin
                if (!rx_sts.empty) begin
                    res.read_valid = 1'b1;
                    res.read_data  = rx_rd_data;
                    rx_ctl.pop     = 1'b1;
                    if (flow_enable_reg && fs_reg == FS_XOFF_SENT && rx_dec < low_ext) begin
                        fs_next = FS_SEND_XON;
                    end
                end
            end
            OP_HOST_WRITE: begin
                tx_ctl.push        = !tx_sts.full;
                res.write_accepted = !tx_sts.full;
            end
            OP_TX_READY: begin
                if (fs_reg == FS_SEND_XOFF) begin
                    res.send_valid = 1'b1;
                    res.send_data  = CH_XOFF;
                    fs_next        = FS_XOFF_SENT;
                end else if (fs_reg == FS_SEND_XON) begin
                    res.send_valid = 1'b1;
                    res.send_data  = CH_XON;
                    fs_next        = FS_XON_SENT;
                end else if (!tx_sts.empty) begin
                    res.send_valid = 1'b1;
                    res.send_data  = tx_rd_data;
                    tx_ctl.pop     = 1'b1;
                end
            end
            OP_FLUSH_RX: begin
                rx_ctl.flush = 1'b1;
                fs_next      = FS_XON_SENT;
            end
            default: ;
        endcase

        rx_fill_after = rx_ctl.flush ? '0
                      : rx_ctl.push ? rx_inc
                      : rx_ctl.pop ? rx_dec
                      : rx_cnt_ext;
        res.rx_fill   = rx_fill_after[FILL_W-1:0];
        res.tx_empty  = tx_ctl.push ? 1'b0 : (tx_ctl.pop ? tx_sts.last : tx_sts.empty);

        if (!go) begin
            rx_ctl  = '0;
            tx_ctl  = '0;
            fs_next = fs_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_ring_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (rx_ctl == '0) && (tx_ctl == '0))
        else $error("ring access outside evaluate cycle");
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> m_valid_reg)
        else $error("evaluated item produced no result");
    a_xoff_needs_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (fs_next == FS_SEND_XOFF && fs_reg != FS_SEND_XOFF) |-> flow_enable_reg)
        else $error("XOFF queued with flow control off");
    a_rx_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rx_ctl.push && rx_ctl.pop) && !(tx_ctl.push && tx_ctl.pop))
        else $error("ring pushed and popped in one cycle");
    a_tx_count_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_sts.empty |-> (tx_count == '0))
        else $error("transmit ring status mismatch");
`endif

endmodule
